/* rtl/rpd_pkg.sv */
package rpd_pkg;

  // pixel format codes as held in the format register
  typedef enum logic [2:0] {
    FMT_RGB565   = 3'd0,
    FMT_RGB555   = 3'd1,
    FMT_RGBA4444 = 3'd2,
    FMT_BGRA8888 = 3'd3,
    FMT_ARGB8888 = 3'd4,
    FMT_ABGR8888 = 3'd5,
    FMT_RGB888   = 3'd6,
    FMT_BGR888   = 3'd7
  } pixel_format_t;

  // configuration register indexes
  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam int RegIndexWidth = 2;
  localparam int DimRegWidth   = 13;
  localparam int CountWidth    = 12;
  localparam int CounterSpan   = 4096;

  localparam logic [DimRegWidth-1:0] WidthReset  = 13'd640;
  localparam logic [DimRegWidth-1:0] HeightReset = 13'd480;

  // configuration as seen by the datapath
  typedef struct packed {
    pixel_format_t          pixel_format;
    logic [DimRegWidth-1:0] image_width;
    logic [DimRegWidth-1:0] image_height;
  } cfg_t;

  // position of one pixel in the frame
  typedef struct packed {
    logic [CountWidth-1:0] column;
    logic [CountWidth-1:0] row;
    logic                  frame_end;
  } pos_t;

  // decoded colour channels
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // widening tables, rounded to v*255/max, filled at elaboration
  localparam int Max4 = 15;
  localparam int Max5 = 31;
  localparam int Max6 = 63;

  typedef logic [15:0][7:0] lut4_t;
  typedef logic [31:0][7:0] lut5_t;
  typedef logic [63:0][7:0] lut6_t;

  function automatic lut4_t build_lut4();
    lut4_t t;
    for (int i = 0; i < 16; i++) begin
      t[i] = 8'((i * 255 + Max4 / 2) / Max4);
    end
    return t;
  endfunction

  function automatic lut5_t build_lut5();
    lut5_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255 + Max5 / 2) / Max5);
    end
    return t;
  endfunction

  function automatic lut6_t build_lut6();
    lut6_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255 + Max6 / 2) / Max6);
    end
    return t;
  endfunction

  localparam lut4_t WIDEN4 = build_lut4();
  localparam lut5_t WIDEN5 = build_lut5();
  localparam lut6_t WIDEN6 = build_lut6();

endpackage

/* rtl/rpd_regs.sv */
module rpd_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 write_enable,
  input  logic [rpd_pkg::RegIndexWidth-1:0]    register_index,
  input  logic [rpd_pkg::DimRegWidth-1:0]      write_data,
  output rpd_pkg::cfg_t                        cfg
);

  // configuration register file, writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format <= rpd_pkg::FMT_RGB565;
      cfg.image_width  <= rpd_pkg::WidthReset;
      cfg.image_height <= rpd_pkg::HeightReset;
    end else if (write_enable) begin
      case (register_index)
        rpd_pkg::REG_PIXEL_FORMAT: begin
          cfg.pixel_format <= rpd_pkg::pixel_format_t'(write_data[2:0]);
        end
        rpd_pkg::REG_IMAGE_WIDTH: begin
          cfg.image_width <= write_data;
        end
        rpd_pkg::REG_IMAGE_HEIGHT: begin
          cfg.image_height <= write_data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/rpd_position.sv */
module rpd_position #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic [rpd_pkg::DimRegWidth-1:0] image_width,
  input  logic [rpd_pkg::DimRegWidth-1:0] image_height,
  output rpd_pkg::pos_t                   pos
);

  localparam int DimLimit = (MAX_DIMENSION < rpd_pkg::CounterSpan) ?
                            MAX_DIMENSION : rpd_pkg::CounterSpan;
  localparam logic [rpd_pkg::DimRegWidth-1:0] LimitValue =
    rpd_pkg::DimRegWidth'(DimLimit);
  localparam logic [rpd_pkg::CountWidth-1:0] LimitLast =
    rpd_pkg::CountWidth'(DimLimit - 1);

  logic [rpd_pkg::CountWidth-1:0] column_count;
  logic [rpd_pkg::CountWidth-1:0] row_count;
  logic [rpd_pkg::CountWidth-1:0] last_column;
  logic [rpd_pkg::CountWidth-1:0] last_row_idx;
  logic [rpd_pkg::DimRegWidth-1:0] width_less;
  logic [rpd_pkg::DimRegWidth-1:0] height_less;
  logic                            last_col;
  logic                            last_row;

  // last index of each dimension, zero acting as one and clamped to the limit
  assign width_less  = image_width - 1'b1;
  assign height_less = image_height - 1'b1;

  always_comb begin
    if (image_width == '0) begin
      last_column = '0;
    end else if (image_width > LimitValue) begin
      last_column = LimitLast;
    end else begin
      last_column = width_less[rpd_pkg::CountWidth-1:0];
    end
    if (image_height == '0) begin
      last_row_idx = '0;
    end else if (image_height > LimitValue) begin
      last_row_idx = LimitLast;
    end else begin
      last_row_idx = height_less[rpd_pkg::CountWidth-1:0];
    end
  end

  // a counter at or past the last index wraps on this pixel
  assign last_col = column_count >= last_column;
  assign last_row = row_count >= last_row_idx;

  assign pos.column    = column_count;
  assign pos.row       = row_count;
  assign pos.frame_end = last_col && last_row;

  // the column counter steps once per accepted transaction, the row counter when the column wraps
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

endmodule

/* rtl/rpd_unpack.sv */
module rpd_unpack (
  input  logic [31:0]           raw_pixel,
  input  rpd_pkg::pixel_format_t pixel_format,
  output rpd_pkg::rgba_t        rgba
);

  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] v16;

  assign b0  = raw_pixel[7:0];
  assign b1  = raw_pixel[15:8];
  assign b2  = raw_pixel[23:16];
  assign b3  = raw_pixel[31:24];
  assign v16 = raw_pixel[15:0];

  // per-format field extraction and widening
  always_comb begin
    rgba.red   = '0;
    rgba.green = '0;
    rgba.blue  = '0;
    rgba.alpha = 8'hFF;
    case (pixel_format)
      rpd_pkg::FMT_RGB565: begin
        rgba.red   = rpd_pkg::WIDEN5[v16[15:11]];
        rgba.green = rpd_pkg::WIDEN6[v16[10:5]];
        rgba.blue  = rpd_pkg::WIDEN5[v16[4:0]];
      end
      rpd_pkg::FMT_RGB555: begin
        rgba.red   = rpd_pkg::WIDEN5[v16[14:10]];
        rgba.green = rpd_pkg::WIDEN5[v16[9:5]];
        rgba.blue  = rpd_pkg::WIDEN5[v16[4:0]];
      end
      rpd_pkg::FMT_RGBA4444: begin
        rgba.red   = rpd_pkg::WIDEN4[v16[15:12]];
        rgba.green = rpd_pkg::WIDEN4[v16[11:8]];
        rgba.blue  = rpd_pkg::WIDEN4[v16[7:4]];
        rgba.alpha = rpd_pkg::WIDEN4[v16[3:0]];
      end
      rpd_pkg::FMT_BGRA8888: begin
        rgba.blue  = b0;
        rgba.green = b1;
        rgba.red   = b2;
        rgba.alpha = b3;
      end
      rpd_pkg::FMT_ARGB8888: begin
        rgba.alpha = b0;
        rgba.red   = b1;
        rgba.green = b2;
        rgba.blue  = b3;
      end
      rpd_pkg::FMT_ABGR8888: begin
        rgba.alpha = b0;
        rgba.blue  = b1;
        rgba.green = b2;
        rgba.red   = b3;
      end
      rpd_pkg::FMT_RGB888: begin
        rgba.red   = b0;
        rgba.green = b1;
        rgba.blue  = b2;
      end
      default: begin
        rgba.blue  = b0;
        rgba.green = b1;
        rgba.red   = b2;
      end
    endcase
  end

endmodule

/* rtl/raw_pixel_to_rgba_decoder.sv */
// Raw pixel to RGBA8888 decoder.
// Input channel: in_valid / in_ready with one 32-bit raw_pixel word per
// transaction, byte 0 in bits 7:0. Output channel: out_valid / out_ready
// carrying red, green, blue, alpha, the pixel's column and row, and
// frame_end on the last pixel of the frame.
// Configuration: write_enable, register_index and write_data; index 0 is the
// pixel format, 1 the image width, 2 the image height. Write only while idle.
// An input transaction passes through an input register, the format decode
// and table lookups, then the result register.
// Throughput is one pixel per clock while out_ready holds; the decode stage
// is a single pass of table lookups and byte selection, so nothing iterates.
// Position counters step when an input transaction is taken, so a pixel's
// column and row follow the order of arrival.
// Reset (rst, synchronous, active high) empties both stages, sets RGB565 at
// 640 by 480 and clears the counters.
// When the receiver stalls the result holds on the outputs; one more pixel
// is taken into the input register, then in_ready drops until the output
// drains.
module raw_pixel_to_rgba_decoder #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 write_enable,
  input  logic [rpd_pkg::RegIndexWidth-1:0]    register_index,
  input  logic [rpd_pkg::DimRegWidth-1:0]      write_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [31:0]                          raw_pixel,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           red,
  output logic [7:0]                           green,
  output logic [7:0]                           blue,
  output logic [7:0]                           alpha,
  output logic [rpd_pkg::CountWidth-1:0]       column,
  output logic [rpd_pkg::CountWidth-1:0]       row,
  output logic                                 frame_end
);

  rpd_pkg::cfg_t  cfg;
  rpd_pkg::pos_t  pos_now;
  rpd_pkg::pos_t  pos_in;
  rpd_pkg::pos_t  pos_out;
  rpd_pkg::rgba_t rgba_dec;
  rpd_pkg::rgba_t rgba_out;
  logic [31:0]    raw_in;
  logic           in_full;
  logic           out_free;
  logic           in_take;

  // configuration registers
  rpd_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .cfg            (cfg)
  );

  // frame position counters
  rpd_position #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_position (
    .clk          (clk),
    .rst          (rst),
    .advance      (in_take),
    .image_width  (cfg.image_width),
    .image_height (cfg.image_height),
    .pos          (pos_now)
  );

  // handshake between the two stages
  assign out_free = !out_valid || out_ready;
  assign in_ready = !in_full || out_free;
  assign in_take  = in_valid && in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      raw_in <= raw_pixel;
      pos_in <= pos_now;
    end
  end

  // format decode
  rpd_unpack u_unpack (
    .raw_pixel    (raw_in),
    .pixel_format (cfg.pixel_format),
    .rgba         (rgba_dec)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_full) begin
      rgba_out <= rgba_dec;
      pos_out  <= pos_in;
    end
  end

  assign red       = rgba_out.red;
  assign green     = rgba_out.green;
  assign blue      = rgba_out.blue;
  assign alpha     = rgba_out.alpha;
  assign column    = pos_out.column;
  assign row       = pos_out.row;
  assign frame_end = pos_out.frame_end;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int MaxDim     = 4096;
  localparam int CycleLimit = 200000;
  localparam int IdlePct    = 12;
  localparam int TailCycles = 8;

  // expected result of one pixel transaction
  typedef struct packed {
    rpd_pkg::rgba_t colour;
    rpd_pkg::pos_t  pos;
  } pixel_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                write_enable = 1'b0;
  logic [rpd_pkg::RegIndexWidth-1:0]   register_index = rpd_pkg::REG_PIXEL_FORMAT;
  logic [rpd_pkg::DimRegWidth-1:0]     write_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [31:0]                         raw_pixel = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [7:0]                          red;
  logic [7:0]                          green;
  logic [7:0]                          blue;
  logic [7:0]                          alpha;
  logic [rpd_pkg::CountWidth-1:0]      column;
  logic [rpd_pkg::CountWidth-1:0]      row;
  logic                                frame_end;

  raw_pixel_to_rgba_decoder #(.MAX_DIMENSION(MaxDim)) uut (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .raw_pixel      (raw_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .alpha          (alpha),
    .column         (column),
    .row            (row),
    .frame_end      (frame_end)
  );

  always #5 clk = ~clk;

  // pixels waiting to be driven and decoded pixels still to arrive
  logic [31:0]   pixel_queue[$];
  pixel_result_t rgba_expected[$];

  // shadow of the block's registers and position counters
  rpd_pkg::pixel_format_t          fmt_model    = rpd_pkg::FMT_RGB565;
  logic [rpd_pkg::DimRegWidth-1:0] width_model  = rpd_pkg::WidthReset;
  logic [rpd_pkg::DimRegWidth-1:0] height_model = rpd_pkg::HeightReset;
  logic [rpd_pkg::CountWidth-1:0]  col_count    = '0;
  logic [rpd_pkg::CountWidth-1:0]  row_count    = '0;

  bit in_fire = 1'b0;
  bit steady  = 1'b0;
  int errors = 0;
  int results_checked = 0;
  int settings_written = 0;
  int cycles = 0;

  function automatic logic [7:0] widen(int v, int maxv);
    return 8'((v * 255 + maxv / 2) / maxv);
  endfunction

  function automatic int clamp_dim(logic [rpd_pkg::DimRegWidth-1:0] r);
    if (r == 0) return 1;
    if (r > MaxDim) return MaxDim;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // write all three registers, one per cycle
  task automatic set_config(rpd_pkg::pixel_format_t f, int w, int h);
    @(negedge clk);
    write_enable   <= 1'b1;
    register_index <= rpd_pkg::REG_PIXEL_FORMAT;
    write_data     <= rpd_pkg::DimRegWidth'(f);
    @(negedge clk);
    register_index <= rpd_pkg::REG_IMAGE_WIDTH;
    write_data     <= rpd_pkg::DimRegWidth'(w);
    @(negedge clk);
    register_index <= rpd_pkg::REG_IMAGE_HEIGHT;
    write_data     <= rpd_pkg::DimRegWidth'(h);
    @(negedge clk);
    write_enable   <= 1'b0;
    settings_written++;
    @(posedge clk);
  endtask

  // wait until every transaction has come out, then let the pipeline settle
  task automatic wait_drain();
    while (pixel_queue.size() != 0 || rgba_expected.size() != 0 || in_valid)
      @(negedge clk);
    repeat (TailCycles) @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pixel_queue.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
        in_valid  <= 1'b1;
        raw_pixel <= pixel_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  // monitor and predictor
  logic [15:0]   half;
  pixel_result_t want;
  int            ew, eh;
  bit            last_col, last_row;

  always @(posedge clk) begin
    in_fire = 1'b0;
    if (!rst) begin
      if (write_enable) begin
        case (register_index)
          rpd_pkg::REG_PIXEL_FORMAT:
            fmt_model = rpd_pkg::pixel_format_t'(write_data[2:0]);
          rpd_pkg::REG_IMAGE_WIDTH:  width_model  = write_data;
          rpd_pkg::REG_IMAGE_HEIGHT: height_model = write_data;
          default: ;
        endcase
      end

      // result side
      if (out_valid && out_ready) begin
        if (rgba_expected.size() == 0) begin
          report("result with nothing pending, red", red, 0);
        end else begin
          want = rgba_expected.pop_front();
          results_checked++;
          if (red !== want.colour.red)     report("red", red, want.colour.red);
          if (green !== want.colour.green) report("green", green, want.colour.green);
          if (blue !== want.colour.blue)   report("blue", blue, want.colour.blue);
          if (alpha !== want.colour.alpha) report("alpha", alpha, want.colour.alpha);
          if (column !== want.pos.column)  report("column", column, want.pos.column);
          if (row !== want.pos.row)        report("row", row, want.pos.row);
          if (frame_end !== want.pos.frame_end)
            report("frame_end", frame_end, want.pos.frame_end);
        end
      end

      // input side: decode colour and place the pixel
      if (in_valid && in_ready) begin
        in_fire = 1'b1;
        half = raw_pixel[15:0];
        want.colour = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'hFF};
        case (fmt_model)
          rpd_pkg::FMT_RGB565: begin
            want.colour.red   = widen(half[15:11], 31);
            want.colour.green = widen(half[10:5], 63);
            want.colour.blue  = widen(half[4:0], 31);
          end
          rpd_pkg::FMT_RGB555: begin
            want.colour.red   = widen(half[14:10], 31);
            want.colour.green = widen(half[9:5], 31);
            want.colour.blue  = widen(half[4:0], 31);
          end
          rpd_pkg::FMT_RGBA4444: begin
            want.colour.red   = widen(half[15:12], 15);
            want.colour.green = widen(half[11:8], 15);
            want.colour.blue  = widen(half[7:4], 15);
            want.colour.alpha = widen(half[3:0], 15);
          end
          rpd_pkg::FMT_BGRA8888: want.colour = {raw_pixel[23:16], raw_pixel[15:8],
                                                raw_pixel[7:0], raw_pixel[31:24]};
          rpd_pkg::FMT_ARGB8888: want.colour = {raw_pixel[15:8], raw_pixel[23:16],
                                                raw_pixel[31:24], raw_pixel[7:0]};
          rpd_pkg::FMT_ABGR8888: want.colour = {raw_pixel[31:24], raw_pixel[23:16],
                                                raw_pixel[15:8], raw_pixel[7:0]};
          rpd_pkg::FMT_RGB888:   want.colour = {raw_pixel[7:0], raw_pixel[15:8],
                                                raw_pixel[23:16], 8'hFF};
          default:               want.colour = {raw_pixel[23:16], raw_pixel[15:8],
                                                raw_pixel[7:0], 8'hFF};
        endcase
        ew = clamp_dim(width_model);
        eh = clamp_dim(height_model);
        last_col = col_count >= ew - 1;
        last_row = row_count >= eh - 1;
        want.pos = '{column: col_count, row: row_count, frame_end: last_col && last_row};
        rgba_expected.push_back(want);
        if (last_col) begin
          col_count = '0;
          row_count = last_row ? '0 : row_count + 1'b1;
        end else begin
          col_count = col_count + 1'b1;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    int n, w, h, pick;
    rpd_pkg::pixel_format_t f;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // every format with both halves of the word at their extremes
    for (int i = 0; i < 8; i++) begin
      set_config(rpd_pkg::pixel_format_t'(i), 4, 2);
      pixel_queue.push_back(32'h0000_FFFF);
      pixel_queue.push_back(32'hFFFF_0000);
      wait_drain();
    end

    // zero width and height act as one: every pixel ends a frame
    set_config(rpd_pkg::FMT_RGB888, 0, 0);
    pixel_queue.push_back(32'h0012_3456);
    pixel_queue.push_back(32'hFFFF_FFFF);
    wait_drain();

    // geometry shrunk mid-row: counter past the new last column wraps the row
    set_config(rpd_pkg::FMT_BGR888, 5, 2);
    repeat (3) pixel_queue.push_back($urandom());
    wait_drain();
    set_config(rpd_pkg::FMT_BGR888, 2, 2);
    repeat (2) pixel_queue.push_back($urandom());
    wait_drain();

    // random phases, counters carried over from one setting to the next
    for (int p = 0; p < 16; p++) begin
      f = (p < 8) ? rpd_pkg::pixel_format_t'(p)
                  : rpd_pkg::pixel_format_t'($urandom_range(7));
      case (p)
        2:       begin w = 4096; h = 1;    end
        5:       begin w = 1;    h = 4096; end
        8:       begin w = 8191; h = 0;    end
        11:      begin w = 0;    h = 8191; end
        13:      begin w = 4097; h = 3;    end
        default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 6); end
      endcase
      steady = (p >= 6 && p <= 7);
      set_config(f, w, h);
      n = $urandom_range(30, 64);
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(7);
        if (pick == 0)      pixel_queue.push_back(32'h0000_0000);
        else if (pick == 1) pixel_queue.push_back(32'hFFFF_FFFF);
        else                pixel_queue.push_back($urandom());
      end
      wait_drain();
    end
    steady = 1'b0;

    $display("checked %0d decoded pixels over %0d register settings, all eight formats",
             results_checked, settings_written);
    $display("geometry covered zero, small, maximum and oversized sizes with mid-frame changes");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
